FILE: rtl/lsrf_pkg.sv
`default_nettype none
package lsrf_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 256;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  localparam int X_W    = 20;
  localparam int Y_W    = 28;
  localparam int CNT_W  = 9;
  localparam int SX_W   = 28;
  localparam int SY_W   = 36;
  localparam int SXX_W  = 48;
  localparam int SYY_W  = 64;
  localparam int SXY_W  = 56;
  localparam int THR_W  = 16;
  localparam int OUT_W  = 48;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 1;
  localparam int PROD_W = 2 * Y_W;

  // batch fit widths
  localparam int DXX_W  = 57;
  localparam int DYY_W  = 73;
  localparam int DXY_W  = 65;
  localparam int T1_W   = 94;
  localparam int DEN_W  = 66;
  localparam int MC_W   = 146;
  localparam int MP_W   = 73;
  localparam int R2_SH  = 16;

  localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST  = 9'd200;
  localparam logic [THR_W-1:0] FIT_THRESHOLD_RST = 16'd58982;

  localparam logic [CIDX_W-1:0] CFG_SAMPLE_COUNT  = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_FIT_THRESHOLD = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_Y, ST_XY, ST_SUM_XY, ST_LOAD, ST_RUN, ST_WB, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    STEP_KXX, STEP_XX, STEP_KYY, STEP_YY, STEP_KXY, STEP_XY, STEP_LHS,
    STEP_TD, STEP_RHS, STEP_SLOPE, STEP_P, STEP_Q, STEP_DEN, STEP_ICPT
  } step_e;

  typedef enum logic [2:0] {
    A_SXX, A_SX, A_SYY, A_SY, A_SXY, A_DXY, A_DXX, A_T1
  } asel_e;

  typedef enum logic [2:0] {
    B_K, B_SX, B_SY, B_DXY, B_DYY, B_THR
  } bsel_e;

  typedef enum logic [3:0] {
    WB_NONE, WB_T1, WB_DXX, WB_DYY, WB_DXY, WB_LHS, WB_OK, WB_NUM, WB_DEN,
    WB_SLOPE, WB_ICPT
  } wb_e;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_XX, ACC_YY, ACC_XY
  } acc_e;

  typedef struct packed {
    logic  sample_load;
    acc_e  acc;
    logic  mul_load;
    asel_e a_sel;
    bsel_e b_sel;
    logic  div_load;
    logic  div_icpt;
    wb_e   wb;
    logic  res_zero;
    logic  out_load;
    logic  clear;
  } cmd_t;

  typedef struct packed {
    logic batch_end;
    logic mul_busy;
    logic div_busy;
    logic dxx_zero;
    logic fit_pass;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/lsrf_ctrl.sv
`default_nettype none
module lsrf_ctrl import lsrf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_KXX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.sample_load = 1'b1;
          state_d           = ST_SQ_Y;
        end
      end
      ST_SQ_Y: begin
        cmd_o.acc = ACC_XX;
        state_d   = ST_XY;
      end
      ST_XY: begin
        cmd_o.acc = ACC_YY;
        state_d   = ST_SUM_XY;
      end
      ST_SUM_XY: begin
        cmd_o.acc = ACC_XY;
        if (stat_i.batch_end) begin
          step_d  = STEP_KXX;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LOAD: begin
        state_d = ST_RUN;
        case (step_q)
          STEP_SLOPE: cmd_o.div_load = 1'b1;
          STEP_ICPT: begin
            cmd_o.div_load = 1'b1;
            cmd_o.div_icpt = 1'b1;
          end
          default: cmd_o.mul_load = 1'b1;
        endcase
        case (step_q)
          STEP_KXX: begin cmd_o.a_sel = A_SXX; cmd_o.b_sel = B_K;   end
          STEP_XX:  begin cmd_o.a_sel = A_SX;  cmd_o.b_sel = B_SX;  end
          STEP_KYY: begin cmd_o.a_sel = A_SYY; cmd_o.b_sel = B_K;   end
          STEP_YY:  begin cmd_o.a_sel = A_SY;  cmd_o.b_sel = B_SY;  end
          STEP_KXY: begin cmd_o.a_sel = A_SXY; cmd_o.b_sel = B_K;   end
          STEP_XY:  begin cmd_o.a_sel = A_SX;  cmd_o.b_sel = B_SY;  end
          STEP_LHS: begin cmd_o.a_sel = A_DXY; cmd_o.b_sel = B_DXY; end
          STEP_TD:  begin cmd_o.a_sel = A_DXX; cmd_o.b_sel = B_THR; end
          STEP_RHS: begin cmd_o.a_sel = A_T1;  cmd_o.b_sel = B_DYY; end
          STEP_P:   begin cmd_o.a_sel = A_DXX; cmd_o.b_sel = B_SY;  end
          STEP_Q:   begin cmd_o.a_sel = A_DXY; cmd_o.b_sel = B_SX;  end
          STEP_DEN: begin cmd_o.a_sel = A_DXX; cmd_o.b_sel = B_K;   end
          default:  begin cmd_o.a_sel = A_SXX; cmd_o.b_sel = B_K;   end
        endcase
      end
      ST_RUN: begin
        if (!stat_i.mul_busy && !stat_i.div_busy) state_d = ST_WB;
      end
      ST_WB: begin
        state_d = ST_LOAD;
        case (step_q)
          STEP_KXX: begin cmd_o.wb = WB_T1;  step_d = STEP_XX;  end
          STEP_XX:  begin cmd_o.wb = WB_DXX; step_d = STEP_KYY; end
          STEP_KYY: begin cmd_o.wb = WB_T1;  step_d = STEP_YY;  end
          STEP_YY:  begin cmd_o.wb = WB_DYY; step_d = STEP_KXY; end
          STEP_KXY: begin cmd_o.wb = WB_T1;  step_d = STEP_XY;  end
          STEP_XY:  begin cmd_o.wb = WB_DXY; step_d = STEP_LHS; end
          STEP_LHS: begin
            cmd_o.wb = WB_LHS;
            // no spread in x: nothing to fit
            if (stat_i.dxx_zero) begin
              cmd_o.res_zero = 1'b1;
              state_d        = ST_DONE;
            end else begin
              step_d = STEP_TD;
            end
          end
          STEP_TD:  begin cmd_o.wb = WB_T1; step_d = STEP_RHS; end
          STEP_RHS: begin
            cmd_o.wb = WB_OK;
            step_d   = stat_i.fit_pass ? STEP_SLOPE : STEP_P;
          end
          STEP_SLOPE: begin cmd_o.wb = WB_SLOPE; step_d = STEP_P;    end
          STEP_P:     begin cmd_o.wb = WB_T1;    step_d = STEP_Q;    end
          STEP_Q:     begin cmd_o.wb = WB_NUM;   step_d = STEP_DEN;  end
          STEP_DEN:   begin cmd_o.wb = WB_DEN;   step_d = STEP_ICPT; end
          STEP_ICPT: begin
            cmd_o.wb = WB_ICPT;
            state_d  = ST_DONE;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clear    = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/lsrf_datapath.sv
`default_nettype none
module lsrf_datapath import lsrf_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CIDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire logic [X_W-1:0]    elapsed_us_i,
  input  wire logic [Y_W-1:0]    cycle_delta_i,
  input  wire cmd_t              cmd_i,
  output stat_t                  stat_o,
  output logic signed [OUT_W-1:0] slope_o,
  output logic signed [OUT_W-1:0] intercept_o,
  output logic                   fit_ok_o
);

  localparam int DIV_W  = 96 + int'(FRAC_BITS);
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int DD_W   = DEN_W + 1;
  localparam int REM_W  = DD_W + 1;
  localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_SAMPLES);
  localparam logic [CNT_W-1:0]  MIN_CNT = CNT_W'(2);
  localparam logic [OUT_W-1:0]  POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0]  NEG_LIM = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(DIV_W);

  logic [CNT_W-1:0]  sample_count_q;
  logic [THR_W-1:0]  thr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SX_W-1:0]   sx_q;
  logic [SY_W-1:0]   sy_q;
  logic [SXX_W-1:0]  sxx_q;
  logic [SYY_W-1:0]  syy_q;
  logic [SXY_W-1:0]  sxy_q;
  logic              end_q;
  logic [X_W-1:0]    x_q;
  logic [Y_W-1:0]    y_q;
  logic [PROD_W-1:0] prod_q;
  logic [MC_W-1:0]   mc_q, acc_q, lhs_q;
  logic [MP_W-1:0]   mp_q;
  logic [T1_W-1:0]   t1_q;
  logic [DXX_W-1:0]  dxx_q;
  logic [DYY_W-1:0]  dyy_q;
  logic [DXY_W-1:0]  dxy_q;
  logic [DEN_W-1:0]  den_q;
  logic              negxy_q, negi_q, ok_q, dneg_q;
  logic [DIV_W-1:0]  n_q;
  logic [DD_W-1:0]   d_q, rem_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [OUT_W-1:0]  slope_q, icpt_q, out_slope_q, out_icpt_q;
  logic              out_ok_q;

  logic [CNT_W-1:0]  need, cnt_inc;
  logic [Y_W-1:0]    ma, mb;
  logic [PROD_W-1:0] prod_d;
  logic [MC_W-1:0]   a_val, t1_ext, dmag, dsum;
  logic [MP_W-1:0]   b_val;
  logic              ge;
  logic [REM_W-1:0]  rem_sh, rem_sub;
  logic              qbit;
  logic              hi_nz, over;
  logic [OUT_W-1:0]  mag, satm, sat_val;

  always_comb begin
    if (sample_count_q < MIN_CNT) need = MIN_CNT;
    else if (sample_count_q > MAX_CNT) need = MAX_CNT;
    else need = sample_count_q;
  end
  assign cnt_inc = cnt_q + 1'b1;

  // one 28x28 multiplier shared by the three per-sample products
  always_comb begin
    case (cmd_i.acc)
      ACC_XX: begin ma = y_q; mb = y_q; end
      ACC_YY: begin ma = Y_W'(x_q); mb = y_q; end
      default: begin ma = Y_W'(elapsed_us_i); mb = Y_W'(elapsed_us_i); end
    endcase
  end
  assign prod_d = ma * mb;

  always_comb begin
    case (cmd_i.a_sel)
      A_SXX:   a_val = MC_W'(sxx_q);
      A_SX:    a_val = MC_W'(sx_q);
      A_SYY:   a_val = MC_W'(syy_q);
      A_SY:    a_val = MC_W'(sy_q);
      A_SXY:   a_val = MC_W'(sxy_q);
      A_DXY:   a_val = MC_W'(dxy_q);
      A_DXX:   a_val = MC_W'(dxx_q);
      A_T1:    a_val = MC_W'(t1_q);
      default: a_val = '0;
    endcase
    case (cmd_i.b_sel)
      B_K:     b_val = MP_W'(cnt_q);
      B_SX:    b_val = MP_W'(sx_q);
      B_SY:    b_val = MP_W'(sy_q);
      B_DXY:   b_val = MP_W'(dxy_q);
      B_DYY:   b_val = dyy_q;
      B_THR:   b_val = MP_W'(thr_q);
      default: b_val = '0;
    endcase
  end

  assign t1_ext = MC_W'(t1_q);
  assign ge     = t1_ext >= acc_q;
  assign dmag   = ge ? (t1_ext - acc_q) : (acc_q - t1_ext);
  assign dsum   = t1_ext + acc_q;

  // restoring divider step, quotient bits shift into the numerator register
  assign rem_sh  = {rem_q, n_q[DIV_W-1]};
  assign qbit    = rem_sh >= REM_W'(d_q);
  assign rem_sub = qbit ? (rem_sh - REM_W'(d_q)) : rem_sh;

  // round-to-nearest quotient saturated to the signed output range
  assign hi_nz   = |n_q[DIV_W-1:OUT_W];
  assign mag     = n_q[OUT_W-1:0];
  assign over    = hi_nz || (dneg_q ? (mag > NEG_LIM) : mag[OUT_W-1]);
  assign satm    = over ? (dneg_q ? NEG_LIM : POS_LIM) : mag;
  assign sat_val = dneg_q ? (~satm + 1'b1) : satm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= SAMPLE_COUNT_RST;
      thr_q          <= FIT_THRESHOLD_RST;
      cnt_q          <= '0;
      sx_q           <= '0;
      sy_q           <= '0;
      sxx_q          <= '0;
      syy_q          <= '0;
      sxy_q          <= '0;
      end_q          <= 1'b0;
      mp_q           <= '0;
      dcnt_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SAMPLE_COUNT:  sample_count_q <= cfg_data_i[CNT_W-1:0];
          CFG_FIT_THRESHOLD: thr_q          <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clear) begin
        cnt_q <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        syy_q <= '0;
        sxy_q <= '0;
      end else if (cmd_i.sample_load) begin
        cnt_q <= cnt_inc;
        end_q <= cnt_inc >= need;
        sx_q  <= sx_q + SX_W'(elapsed_us_i);
        sy_q  <= sy_q + SY_W'(cycle_delta_i);
      end else begin
        case (cmd_i.acc)
          ACC_XX:  sxx_q <= sxx_q + SXX_W'(prod_q);
          ACC_YY:  syy_q <= syy_q + SYY_W'(prod_q);
          ACC_XY:  sxy_q <= sxy_q + SXY_W'(prod_q);
          default: ;
        endcase
      end
      if (cmd_i.mul_load) mp_q <= b_val;
      else if (mp_q != '0) mp_q <= mp_q >> 1;
      if (cmd_i.div_load) dcnt_q <= DIV_STEPS;
      else if (dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_load) begin
      x_q <= elapsed_us_i;
      y_q <= cycle_delta_i;
    end
    if (cmd_i.sample_load || cmd_i.acc == ACC_XX || cmd_i.acc == ACC_YY) prod_q <= prod_d;

    // shift-add multiplier, stops when the multiplier operand runs out of ones
    if (cmd_i.mul_load) begin
      mc_q  <= a_val;
      acc_q <= '0;
    end else if (mp_q != '0) begin
      if (mp_q[0]) acc_q <= acc_q + mc_q;
      mc_q <= mc_q << 1;
    end

    if (cmd_i.div_load) begin
      rem_q <= '0;
      if (cmd_i.div_icpt) begin
        n_q    <= (DIV_W'(t1_q) << (FRAC_BITS + 1)) + DIV_W'(den_q);
        d_q    <= {den_q, 1'b0};
        dneg_q <= negi_q;
      end else begin
        n_q    <= (DIV_W'(dxy_q) << (FRAC_BITS + 1)) + DIV_W'(dxx_q);
        d_q    <= DD_W'({dxx_q, 1'b0});
        dneg_q <= negxy_q;
      end
    end else if (dcnt_q != '0) begin
      rem_q <= rem_sub[DD_W-1:0];
      n_q   <= {n_q[DIV_W-2:0], qbit};
    end

    case (cmd_i.wb)
      WB_T1:  t1_q  <= acc_q[T1_W-1:0];
      WB_DXX: dxx_q <= dmag[DXX_W-1:0];
      WB_DYY: dyy_q <= dmag[DYY_W-1:0];
      WB_DXY: begin
        dxy_q   <= dmag[DXY_W-1:0];
        negxy_q <= !ge;
      end
      WB_LHS: lhs_q <= acc_q << R2_SH;
      WB_OK: begin
        ok_q    <= lhs_q >= acc_q;
        slope_q <= '0;
      end
      WB_NUM: begin
        // negative slope: the two intercept terms add
        t1_q   <= negxy_q ? dsum[T1_W-1:0] : dmag[T1_W-1:0];
        negi_q <= negxy_q ? 1'b0 : !ge;
      end
      WB_DEN:   den_q   <= acc_q[DEN_W-1:0];
      WB_SLOPE: slope_q <= sat_val;
      WB_ICPT:  icpt_q  <= sat_val;
      default: ;
    endcase
    if (cmd_i.res_zero) begin
      slope_q <= '0;
      icpt_q  <= '0;
      ok_q    <= 1'b0;
    end
    if (cmd_i.out_load) begin
      out_slope_q <= slope_q;
      out_icpt_q  <= icpt_q;
      out_ok_q    <= ok_q;
    end
  end

  assign stat_o.batch_end = end_q;
  assign stat_o.mul_busy  = mp_q != '0;
  assign stat_o.div_busy  = dcnt_q != '0;
  assign stat_o.dxx_zero  = dxx_q == '0;
  assign stat_o.fit_pass  = lhs_q >= acc_q;

  assign slope_o     = out_slope_q;
  assign intercept_o = out_icpt_q;
  assign fit_ok_o    = out_ok_q;

endmodule
`default_nettype wire

FILE: rtl/least_squares_rate_fit_unit.sv
// sample beat: accepted when idle, then summed in the SQ_Y, XY and SUM_XY states before the next beat is taken
// batch end: up to 12 shift-add multiplies, each running until the multiplier has no ones
// left, and up to two restoring divides (the slope divide only when the fit passes)
// the result sits in an output register while the next batch is taken
// async active-low reset: sums and count cleared, sample_count 200, threshold 58982
`default_nettype none
module least_squares_rate_fit_unit import lsrf_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CIDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [X_W-1:0]     elapsed_us_i,
  input  wire logic [Y_W-1:0]     cycle_delta_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [OUT_W-1:0] slope_o,
  output logic signed [OUT_W-1:0] intercept_o,
  output logic                    fit_ok_o
);

  cmd_t  cmd;
  stat_t stat;

  lsrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lsrf_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .elapsed_us_i  (elapsed_us_i),
    .cycle_delta_i (cycle_delta_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .slope_o       (slope_o),
    .intercept_o   (intercept_o),
    .fit_ok_o      (fit_ok_o)
  );

endmodule
`default_nettype wire

FILE: rtl/lsrf_checker.sv
`default_nettype none
module lsrf_checker import lsrf_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic signed [OUT_W-1:0] slope_o,
  input wire logic                    fit_ok_o
);

  // the sum update keeps the input side busy after every beat
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slope_o))
    else $error("stalled result changed");

  a_fail_zero_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fit_ok_o |-> slope_o == '0)
    else $error("failed fit with nonzero slope");

endmodule

bind least_squares_rate_fit_unit lsrf_checker u_chk (.*);
`default_nettype wire

FILE: bench/least_squares_rate_fit_unit_tb.sv
`timescale 1ns / 1ps
module least_squares_rate_fit_unit_tb;
  import lsrf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned ITEM_GOAL = 1100;

  typedef logic [255:0] wide_t;

  typedef struct {
    logic signed [OUT_W-1:0] slope;
    logic signed [OUT_W-1:0] intercept;
    logic ok;
  } fit_t;

  typedef struct {
    int unsigned cnt;  // nonzero: settle, then set sample_count before this beat
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    bit typed;
    logic signed [OUT_W-1:0] slope;
    logic signed [OUT_W-1:0] intercept;
    logic ok;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CIDX_W-1:0] cfg_index_i = CFG_SAMPLE_COUNT;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [X_W-1:0] elapsed_us_i = '0;
  logic [Y_W-1:0] cycle_delta_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic signed [OUT_W-1:0] slope_o;
  logic signed [OUT_W-1:0] intercept_o;
  logic fit_ok_o;

  least_squares_rate_fit_unit DUT (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [CNT_W-1:0] batch_len = SAMPLE_COUNT_RST;
  logic [THR_W-1:0] r2_floor = FIT_THRESHOLD_RST;
  logic [CNT_W-1:0] n_seen = '0;
  logic [SX_W-1:0] acc_x = '0;
  logic [SY_W-1:0] acc_y = '0;
  logic [SXX_W-1:0] acc_xx = '0;
  logic [SYY_W-1:0] acc_yy = '0;
  logic [SXY_W-1:0] acc_xy = '0;

  fit_t pending_fits[$];
  bit quiet = 1'b0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;

  function automatic logic [OUT_W-1:0] round_sat(wide_t mag, bit neg, wide_t den);
    wide_t q;
    wide_t lim;
    q = ((mag << 1) + den) / (den << 1);
    lim = neg ? (wide_t'(1) << 47) : ((wide_t'(1) << 47) - 1);
    if (q > lim) q = lim;
    if (neg) q = -q;
    return q[OUT_W-1:0];
  endfunction

  // accumulate one beat; push a fit when the batch closes
  task automatic accumulate_sample(logic [X_W-1:0] x, logic [Y_W-1:0] y, bit typed,
                                   fit_t typed_fit);
    int unsigned need;
    wide_t k, sx, sy, t1, t2, dxx, dyy, dxy, lhs, rhs, p, q, num;
    bit negxy, negi;
    fit_t f;
    need = batch_len;
    if (need < 2) need = 2;
    if (need > 256) need = 256;
    acc_x = acc_x + x;
    acc_y = acc_y + y;
    acc_xx = acc_xx + SXX_W'(64'(x) * 64'(x));
    acc_yy = acc_yy + 64'(y) * 64'(y);
    acc_xy = acc_xy + SXY_W'(64'(x) * 64'(y));
    n_seen = n_seen + 1'b1;
    if (n_seen < need) return;
    k = n_seen; sx = acc_x; sy = acc_y;
    t1 = k * wide_t'(acc_xx); t2 = sx * sx;
    dxx = (t1 >= t2) ? t1 - t2 : t2 - t1;
    t1 = k * wide_t'(acc_yy); t2 = sy * sy;
    dyy = (t1 >= t2) ? t1 - t2 : t2 - t1;
    t1 = k * wide_t'(acc_xy); t2 = sx * sy;
    negxy = t1 < t2;
    dxy = negxy ? t2 - t1 : t1 - t2;
    f.slope = '0; f.intercept = '0; f.ok = 1'b0;
    if (dxx != 0) begin
      lhs = (dxy * dxy) << 16;
      rhs = wide_t'(r2_floor) * dxx * dyy;
      f.ok = lhs >= rhs;
      if (f.ok) f.slope = round_sat(dxy << FRAC_BITS_DEF, negxy, dxx);
      p = sy * dxx;
      q = dxy * sx;
      if (!negxy) begin
        negi = p < q;
        num = negi ? q - p : p - q;
      end else begin
        num = p + q;
        negi = 1'b0;
      end
      f.intercept = round_sat(num << FRAC_BITS_DEF, negi, k * dxx);
    end
    n_seen = '0; acc_x = '0; acc_y = '0; acc_xx = '0; acc_yy = '0; acc_xy = '0;
    pending_fits.push_back(typed ? typed_fit : f);
  endtask

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_sample(logic [X_W-1:0] x, logic [Y_W-1:0] y, bit typed = 0,
                             fit_t typed_fit = '{default: '0});
    if (!quiet && $urandom_range(99) < 38) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    elapsed_us_i = x;
    cycle_delta_i = y;
    do @(posedge clk_i); while (in_stall_o);
    accumulate_sample(x, y, typed, typed_fit);
    items_sent++;
    @(negedge clk_i);
  endtask

  // let every outstanding fit arrive and the block go quiet
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending_fits.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_SAMPLE_COUNT) batch_len = val[CNT_W-1:0];
    else r2_floor = val[THR_W-1:0];
  endtask

  // receiver stalls at random
  always @(negedge clk_i)
    out_stall_i <= !rst_ni ? 1'b1 : (!quiet && $urandom_range(99) < 38);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_fits.size() == 0) begin
        $display("%0t: unexpected fit slope=%0d intercept=%0d ok=%0b", $time,
                 slope_o, intercept_o, fit_ok_o);
        errors++;
      end else begin
        fit_t e;
        e = pending_fits.pop_front();
        if (slope_o !== e.slope) begin
          $display("%0t: slope expected %0d actual %0d", $time, e.slope, slope_o);
          errors++;
        end
        if (intercept_o !== e.intercept) begin
          $display("%0t: intercept expected %0d actual %0d", $time, e.intercept,
                   intercept_o);
          errors++;
        end
        if (fit_ok_o !== e.ok) begin
          $display("%0t: fit_ok expected %0b actual %0b", $time, e.ok, fit_ok_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("least_squares_rate_fit_unit_tb: errors");
      $finish;
    end
  end

  row_t dir_rows[] = '{
    '{2, 20'd0, 28'd0, 0, 0, 0, 0},
    '{0, 20'd1, 28'd1, 1, 48'sd65536, 48'sd0, 1'b1},
    '{0, 20'd5, 28'd7, 0, 0, 0, 0},
    '{0, 20'd5, 28'd9, 1, 48'sd0, 48'sd0, 1'b0},
    '{0, 20'd0, 28'd5, 0, 0, 0, 0},
    '{0, 20'd10, 28'd5, 1, 48'sd0, 48'sd327680, 1'b1},
    '{0, 20'hFFFFF, 28'hFFFFFFF, 0, 0, 0, 0},
    '{0, 20'd0, 28'd0, 0, 0, 0, 0},
    '{0, 20'hFFFFF, 28'd0, 0, 0, 0, 0},
    '{0, 20'd0, 28'hFFFFFFF, 0, 0, 0, 0},
    '{0, 20'hFFFFF, 28'hFFFFFFF, 0, 0, 0, 0},
    '{0, 20'hFFFFF, 28'hFFFFFFF, 1, 48'sd0, 48'sd0, 1'b0},
    '{0, 20'd1, 28'd0, 0, 0, 0, 0},
    '{0, 20'd0, 28'hFFFFFFF, 0, 0, 0, 0},
    // poor fit: slope forced to zero, intercept still fitted
    '{3, 20'd0, 28'd0, 0, 0, 0, 0},
    '{0, 20'd1, 28'd100, 0, 0, 0, 0},
    '{0, 20'd2, 28'd0, 0, 0, 0, 0},
    '{0, 20'h55555, 28'hAAAAAAA, 0, 0, 0, 0},
    '{0, 20'hAAAAA, 28'h5555555, 0, 0, 0, 0},
    '{0, 20'h12345, 28'h0F0F0F0, 0, 0, 0, 0}
  };

  initial begin
    int unsigned mode, rate, base, cx, cy, n_items, len_pick, xmax;
    logic [63:0] yv;
    logic [X_W-1:0] x;
    fit_t tf;
    bit wide_done;
    bit force_quiet;
    wide_done = 0;
    force_quiet = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cnt != 0) begin
        settle();
        write_reg(CFG_SAMPLE_COUNT, CFG_W'(dir_rows[i].cnt));
      end
      tf.slope = dir_rows[i].slope;
      tf.intercept = dir_rows[i].intercept;
      tf.ok = dir_rows[i].ok;
      send_sample(dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed, tf);
    end

    while (items_sent < ITEM_GOAL) begin
      // reconfigure between phases, leftover samples stay in the batch
      settle();
      len_pick = $urandom_range(99);
      if (!wide_done && items_sent > 500) begin
        write_reg(CFG_SAMPLE_COUNT, 16'd256);
        wide_done = 1;
        // one long batch with no idling on either side
        force_quiet = 1;
      end else if (len_pick < 4) write_reg(CFG_SAMPLE_COUNT, CFG_W'($urandom_range(0, 1)));
      else if (len_pick < 7) write_reg(CFG_SAMPLE_COUNT, 16'hFFFF);
      else if (len_pick < 10) write_reg(CFG_SAMPLE_COUNT, 16'd300);
      else write_reg(CFG_SAMPLE_COUNT, CFG_W'($urandom_range(2, 9)));
      case ($urandom_range(4))
        0: write_reg(CFG_FIT_THRESHOLD, 16'd0);
        1: write_reg(CFG_FIT_THRESHOLD, 16'hFFFF);
        2: write_reg(CFG_FIT_THRESHOLD, FIT_THRESHOLD_RST);
        default: write_reg(CFG_FIT_THRESHOLD, CFG_W'($urandom));
      endcase
      quiet = force_quiet || ($urandom_range(9) == 0);
      force_quiet = 0;
      n_items = (batch_len == 256 || batch_len > 300) ? 256 + $urandom_range(0, 3)
                                                      : $urandom_range(4, 40);
      mode = $urandom_range(9);
      rate = $urandom_range(0, 255);
      base = $urandom_range(0, 100000);
      xmax = $urandom_range(0, 1) ? 1000 : 20'hFFFFF;
      cx = $urandom & 20'hFFFFF;
      cy = $urandom & 28'hFFFFFFF;
      for (int i = 0; i < n_items; i++) begin
        if (i % 5 == 0 && $urandom_range(3) == 0) mode = $urandom_range(9);
        x = X_W'($urandom_range(0, xmax));
        yv = 64'(base) + 64'(rate) * 64'(x) + 64'($urandom_range(0, 15));
        if (yv > 64'hFFFFFFF) yv = 64'hFFFFFFF;
        case (mode)
          6: send_sample(X_W'($urandom), Y_W'($urandom));
          7: send_sample(X_W'(cx), Y_W'($urandom));
          8: send_sample(X_W'($urandom), Y_W'(cy));
          9: send_sample(X_W'($urandom & 20'hFFFFF), Y_W'($urandom & 28'hFFFFFFF));
          default: send_sample(x, yv[Y_W-1:0]);
        endcase
      end
      quiet = 0;
      // sender waits for the whole backlog before the next phase
    end

    settle();
    if (errors == 0 && pending_fits.size() == 0) begin
      $display("least_squares_rate_fit_unit_tb: clean");
    end else begin
      $display("least_squares_rate_fit_unit_tb: errors");
    end
    $finish;
  end

endmodule
